// File: sv/bss_pkg.sv
// Shared types and constants of the bit string search block.
`timescale 1ns / 1ps
package bss_pkg;

  localparam int SLOT_W     = 6;
  localparam int LEN_W      = 9;
  localparam int FB_W       = 3;
  localparam int WIN_W      = 32;
  localparam int CNT_W      = 32;
  localparam int OUT_OFF_W  = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;
  localparam int LANES      = 8;
  localparam int LANE_W     = 3;
  localparam int SLICE_W    = 2 * LANES - 1;

  localparam logic [LEN_W-1:0] NEEDLE_LENGTH_RST    = 9'd14;
  localparam logic [FB_W-1:0]  NEEDLE_FIRST_BIT_RST = 3'd0;
  localparam logic [WIN_W-1:0] SEARCH_START_RST     = 32'd0;
  localparam logic [WIN_W-1:0] SEARCH_LENGTH_RST    = 32'hFFFF_FFFF;
  localparam logic [LANE_W-1:0] BIT_IN_BYTE         = 3'h7;

  localparam logic [REG_IDX_W-1:0] REG_NEEDLE_LENGTH    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NEEDLE_FIRST_BIT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SEARCH_START     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SEARCH_LENGTH    = 2'd3;

  localparam logic KIND_NEEDLE = 1'b0;
  localparam logic KIND_HAY    = 1'b1;

  typedef struct packed {
    logic shift;
    logic flush;
  } bss_cell_ctl_t;

endpackage

// File: sv/bss_in_if.sv
// Input channel: needle loads and haystack bytes.
`timescale 1ns / 1ps
interface bss_in_if;
  import bss_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [SLOT_W-1:0] needle_slot;
  logic [7:0]        data_byte;
  logic              last;

  modport source (output valid, kind, needle_slot, data_byte, last, input ready);
  modport sink   (input valid, kind, needle_slot, data_byte, last, output ready);
endinterface

// File: sv/bss_out_if.sv
// Result channel: found flag and match offset.
`timescale 1ns / 1ps
interface bss_out_if;
  import bss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [OUT_OFF_W-1:0] match_offset;

  modport source (output valid, found, match_offset, input ready);
  modport sink   (input valid, found, match_offset, output ready);
endinterface

// File: sv/bss_cell.sv
// One haystack byte cell: holds a byte, shifts it on, and checks eight lanes.
`timescale 1ns / 1ps
module bss_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bss_pkg::bss_cell_ctl_t          ctl,
  input  logic [7:0]                      din,
  input  logic [bss_pkg::SLICE_W-1:0]     ndl,
  input  logic [bss_pkg::SLICE_W-1:0]     msk,
  output logic [7:0]                      q,
  output logic [bss_pkg::LANES-1:0]       mism
);
  import bss_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.shift) begin
      byte_nxt = din;
    end else if (ctl.flush) begin
      byte_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // lane j compares hay bit b with aligned needle bit at slice offset 7+b-j
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      mism[j] = 1'b0;
      for (int b = 0; b < 8; b++) begin
        mism[j] = mism[j] | ((byte_r[b] ^ ndl[7 + b - j]) & msk[7 + b - j]);
      end
    end
  end

  assign q = byte_r;
endmodule

// File: sv/bss_align.sv
// Needle aligner: end-aligns the needle bits and their mask to the newest haystack byte.
`timescale 1ns / 1ps
module bss_align #(
  parameter int DEPTH = 33,
  parameter int SHW   = 9
) (
  input  logic                     clk,
  input  logic [8*DEPTH-1:0]       nflat,
  input  logic [bss_pkg::FB_W-1:0] fb,
  input  logic [SHW-1:0]           sh,
  output logic [8*(DEPTH-1):0]     aln_needle,
  output logic [8*(DEPTH-1):0]     aln_mask
);
  import bss_pkg::*;

  localparam int HB = 8 * (DEPTH - 1);

  logic [8*DEPTH-1:0] nf;
  logic [8*DEPTH-1:0] nsh;
  logic [HB:0]        align_r;
  logic [HB:0]        align_nxt;
  logic [HB:0]        mask_r;
  logic [HB:0]        mask_nxt;

  always_comb begin
    nf        = nflat >> fb;
    nsh       = nf << sh;
    align_nxt = nsh[HB:0];
    for (int t = 0; t <= HB; t++) begin
      mask_nxt[t] = (SHW'(t) >= sh);
    end
  end

  always_ff @(posedge clk) begin
    align_r <= align_nxt;
    mask_r  <= mask_nxt;
  end

  assign aln_needle = align_r;
  assign aln_mask   = mask_r;
endmodule

// File: sv/bit_string_search.sv
// Top level of the bit string search block.
// A result beat passes the compare stage register, then the result register.
// Throughput: one beat per cycle, needle loads and haystack bytes alike; input stalls
// only while a held result beat waits for out_bus.ready and a new one is due.
// Reset (rst_n, synchronous): clears cells, counters, result and registers to defaults.
// The needle store is not reset and holds garbage until loaded.
`timescale 1ns / 1ps
module bit_string_search #(
  parameter int MAX_NEEDLE_BITS = 256,
  parameter int OFFSET_WIDTH    = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bss_in_if.sink                         in_bus,
  bss_out_if.source                      out_bus,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bss_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bss_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bss_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bss_pkg::*;

  localparam int DEPTH = (MAX_NEEDLE_BITS + 7) / 8 + 1;
  localparam int HB    = 8 * (DEPTH - 1);
  localparam int SHW   = $clog2(HB + 2);
  localparam int EW    = (OFFSET_WIDTH + 1 > 36) ? OFFSET_WIDTH + 1 : 36;
  localparam int LCAP  = (MAX_NEEDLE_BITS < 511) ? MAX_NEEDLE_BITS : 511;
  localparam logic [EW-1:0] OMASK = EW'((64'd1 << OFFSET_WIDTH) - 64'd1);

  // configuration registers
  logic [LEN_W-1:0] nlen_r;
  logic [FB_W-1:0]  nfb_r;
  logic [WIN_W-1:0] sstart_r;
  logic [WIN_W-1:0] slen_r;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nlen_r   <= NEEDLE_LENGTH_RST;
      nfb_r    <= NEEDLE_FIRST_BIT_RST;
      sstart_r <= SEARCH_START_RST;
      slen_r   <= SEARCH_LENGTH_RST;
    end else if (cfg_wr) begin
      case (paddr[CFG_ADDR_W-1:2])
        REG_NEEDLE_LENGTH:    nlen_r   <= pwdata[LEN_W-1:0];
        REG_NEEDLE_FIRST_BIT: nfb_r    <= pwdata[FB_W-1:0];
        REG_SEARCH_START:     sstart_r <= pwdata[WIN_W-1:0];
        REG_SEARCH_LENGTH:    slen_r   <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_ADDR_W-1:2])
      REG_NEEDLE_LENGTH:    prdata = CFG_DATA_W'(nlen_r);
      REG_NEEDLE_FIRST_BIT: prdata = CFG_DATA_W'(nfb_r);
      REG_SEARCH_START:     prdata = CFG_DATA_W'(sstart_r);
      REG_SEARCH_LENGTH:    prdata = CFG_DATA_W'(slen_r);
      default:              prdata = '0;
    endcase
  end

  // clamp length, derive window bounds on candidate end+1
  logic [LEN_W-1:0] len_eff;
  logic [SHW-1:0]   sh;
  logic [LEN_W-1:0] len_r;
  logic [EW-1:0]    lo_r;
  logic [EW-1:0]    hi_r;
  logic [EW-1:0]    om_r;

  always_comb begin
    len_eff = nlen_r;
    if (nlen_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (nlen_r > LEN_W'(LCAP)) begin
      len_eff = LEN_W'(LCAP);
    end
    sh = SHW'(HB + 1) - SHW'({{SHW{1'b0}}, len_eff});
  end

  always_ff @(posedge clk) begin
    len_r <= len_eff;
    lo_r  <= EW'(sstart_r) + EW'(len_eff);
    hi_r  <= EW'(sstart_r) + EW'(slen_r);
    om_r  <= OMASK + EW'(len_eff);
  end

  // input handshake
  logic in_acc;
  logic hay_acc;
  logic ndl_acc;

  assign in_acc  = in_bus.valid && in_bus.ready;
  assign hay_acc = in_acc && (in_bus.kind == KIND_HAY);
  assign ndl_acc = in_acc && (in_bus.kind == KIND_NEEDLE);

  // needle store
  logic [7:0]         nst_r [DEPTH];
  logic [8*DEPTH-1:0] nflat;

  for (genvar e = 0; e < DEPTH; e++) begin : g_nst
    always_ff @(posedge clk) begin
      if (ndl_acc && ({{(32 - SLOT_W){1'b0}}, in_bus.needle_slot} == 32'(e))) begin
        nst_r[e] <= in_bus.data_byte;
      end
    end
    assign nflat[8*e +: 8] = nst_r[e];
  end

  logic [HB:0] aln_needle;
  logic [HB:0] aln_mask;

  bss_align #(
    .DEPTH (DEPTH),
    .SHW   (SHW)
  ) u_align (
    .clk        (clk),
    .nflat      (nflat),
    .fb         (nfb_r),
    .sh         (sh),
    .aln_needle (aln_needle),
    .aln_mask   (aln_mask)
  );

  // compare stage and search state
  logic             a_valid_r;
  logic             a_last_r;
  logic [CNT_W-1:0] a_idx_r;
  logic [CNT_W-1:0] cnt_r;
  logic             rep_r;
  logic             a_emit;
  logic             a_adv;
  logic             a_done;
  logic [CNT_W-1:0] cnt_eff;

  // cell row
  bss_cell_ctl_t      cctl;
  logic [7:0]         cq   [DEPTH];
  logic [7:0]         cdin [DEPTH];
  logic [LANES-1:0]   cmis [DEPTH];
  logic [HB+15:0]     ap;
  logic [HB+15:0]     mp;

  assign cctl.shift = hay_acc;
  assign cctl.flush = a_done;
  assign ap = {7'b0, aln_needle, 8'b0};
  assign mp = {7'b0, aln_mask, 8'b0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cdin[i] = in_bus.data_byte;
    end else begin : g_body
      assign cdin[i] = a_done ? 8'd0 : cq[i-1];
    end
    bss_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (cctl),
      .din   (cdin[i]),
      .ndl   (ap[8*(DEPTH-1-i)+1 +: SLICE_W]),
      .msk   (mp[8*(DEPTH-1-i)+1 +: SLICE_W]),
      .q     (cq[i]),
      .mism  (cmis[i])
    );
  end

  logic [LANES-1:0]  mis_all;
  logic [LANES-1:0]  lane_ok;
  logic [EW-1:0]     endp [LANES];
  logic [LANES-1:0]  lane_hit;
  logic              hit_raw;
  logic [LANE_W-1:0] sel_j;
  logic [OUT_OFF_W-1:0] hit_off;

  always_comb begin
    mis_all = '0;
    for (int i = 0; i < DEPTH; i++) begin
      mis_all = mis_all | cmis[i];
    end
  end

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      endp[j]    = EW'({a_idx_r, LANE_W'(j)}) + EW'(1);
      lane_ok[j] = (endp[j] >= lo_r) && (endp[j] <= hi_r) && (endp[j] <= om_r);
    end
    lane_hit = lane_ok & ~mis_all;
  end

  always_comb begin
    hit_raw = 1'b0;
    sel_j   = '0;
    for (int j = LANES - 1; j >= 0; j--) begin
      if (lane_hit[j]) begin
        hit_raw = 1'b1;
        sel_j   = LANE_W'(j);
      end
    end
    hit_off = OUT_OFF_W'({a_idx_r, sel_j} + (CNT_W + LANE_W)'(1)
                         - (CNT_W + LANE_W)'(len_r));
  end

  logic             ov_r;
  logic             of_found_r;
  logic [OUT_OFF_W-1:0] of_off_r;

  assign a_emit  = a_valid_r && !rep_r && (hit_raw || a_last_r);
  assign a_adv   = a_valid_r && (!a_emit || !ov_r || out_bus.ready);
  assign a_done  = a_adv && a_last_r;
  assign cnt_eff = a_done ? '0 : cnt_r;
  assign in_bus.ready = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_last_r  <= 1'b0;
      a_idx_r   <= '0;
      cnt_r     <= '0;
      rep_r     <= 1'b0;
    end else begin
      if (hay_acc) begin
        a_valid_r <= 1'b1;
        a_last_r  <= in_bus.last;
        a_idx_r   <= cnt_eff;
        cnt_r     <= (cnt_eff == '1) ? cnt_eff : cnt_eff + CNT_W'(1);
      end else begin
        if (a_adv) begin
          a_valid_r <= 1'b0;
        end
        cnt_r <= cnt_eff;
      end
      if (a_adv) begin
        if (a_last_r) begin
          rep_r <= 1'b0;
        end else if (a_emit) begin
          rep_r <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (a_adv && a_emit) begin
      ov_r <= 1'b1;
    end else if (out_bus.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_emit) begin
      of_found_r <= hit_raw;
      of_off_r   <= hit_raw ? hit_off : '0;
    end
  end

  assign out_bus.valid        = ov_r;
  assign out_bus.found        = of_found_r;
  assign out_bus.match_offset = of_off_r;

  // not-found beats carry a zero offset
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !of_found_r) |-> (of_off_r == '0))
    else $error("not-found beat with nonzero offset");

  // a finished search with no new byte leaves the count at zero
  a_cnt_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (a_done && !hay_acc) |=> (cnt_r == '0))
    else $error("byte count not cleared after final byte");

  // a finished search with no new byte flushes the newest cell
  a_cell_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (a_done && !hay_acc) |=> (cq[0] == 8'd0))
    else $error("cell row not flushed after final byte");

  // a byte index never runs ahead of the running count
  a_idx_order: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !a_last_r && (cnt_r != '1)) |-> (cnt_r == a_idx_r + CNT_W'(1)))
    else $error("byte index out of step with count");
endmodule
